[src/tgrs_pkg.sv]
// Shared types, constants and the arctangent table for the tilt row-scan core.
// No dependencies.
package tgrs_pkg;

    localparam int ANGLE_FRAC_BITS = 4;
    localparam int ANG_W           = ANGLE_FRAC_BITS + 8;
    localparam int CORDIC_ITERS    = 20;
    localparam int ITER_W          = 5;
    localparam int PREC_SHIFT      = 12;
    localparam int ACC_W           = 25;
    localparam int CFG_W           = 11;
    localparam int ROUND_SH        = 16 - ANGLE_FRAC_BITS;

    localparam logic [1:0] CFG_ROWS   = 2'd0;
    localparam logic [1:0] CFG_THR    = 2'd1;
    localparam logic [1:0] CFG_WIN    = 2'd2;
    localparam logic [1:0] CFG_WARN   = 2'd3;

    localparam logic CMD_ARM    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ROW_START = 3'd1;
    localparam logic [2:0] EV_ROW_END   = 3'd2;
    localparam logic [2:0] EV_SCAN_DONE = 3'd3;
    localparam logic [2:0] EV_EMPTY     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQA,
        S_SQB,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_ROT_GO,
        S_ROT_WAIT,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [ACC_W-2:0] f_atan(input logic [ITER_W-1:0] idx);
        logic [ACC_W-2:0] v;
        unique case (idx)
            5'd0:  v = 24'd2949120;
            5'd1:  v = 24'd1740967;
            5'd2:  v = 24'd919879;
            5'd3:  v = 24'd466945;
            5'd4:  v = 24'd234379;
            5'd5:  v = 24'd117304;
            5'd6:  v = 24'd58666;
            5'd7:  v = 24'd29335;
            5'd8:  v = 24'd14668;
            5'd9:  v = 24'd7334;
            5'd10: v = 24'd3667;
            5'd11: v = 24'd1833;
            5'd12: v = 24'd917;
            5'd13: v = 24'd458;
            5'd14: v = 24'd229;
            5'd15: v = 24'd115;
            5'd16: v = 24'd57;
            5'd17: v = 24'd29;
            5'd18: v = 24'd14;
            5'd19: v = 24'd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/tilt_gesture_row_scan_controller_core.sv]
// Top level: sequencer, sample squaring, row-scan decisions, stream ports.
// Depends on tgrs_pkg, tgrs_isqrt, tgrs_cordic.
//
//  channel   dir  handshake                      content
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tuser=command, tdata=x,y,z
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata=event..scan_active
//  cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_data
//
// Each sample runs two passes of squaring, bit-serial root and CORDIC
// (roll, then pitch) between the accept and the decide step, with
// N = SAMPLE_BITS+12 root bits (26 at 14 bits).
// An arm command or an all-zero sample goes straight to the decide step.
// Input is not ready until the item is decided; a waiting result beat
// holds the decide step until it is taken. Reset is synchronous, active low.
module tilt_gesture_row_scan_controller_core import tgrs_pkg::*; #(
    parameter int SAMPLE_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // accel_x, accel_y, accel_z, zero fill
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // command
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // event_res, roll_angle, pitch_angle, angles_valid, scanning, blue_led,
    // red_led, rows_done, scan_active, zero fill
    output logic [39:0]           o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);
    localparam int S = SAMPLE_BITS;
    localparam int N = S + PREC_SHIFT;

    t_state r_state, n_state;

    logic [3:0]       r_rows_cfg;
    logic [CFG_W-1:0] r_thr, r_win, r_warn;

    logic                  r_cmd, r_phase, r_valid;
    logic signed [S-1:0]   r_x, r_y, r_z;
    logic [2*S-1:0]        r_sq;
    logic signed [ANG_W-1:0] r_roll, r_pitch;

    logic       r_active, r_row, r_blue, r_red;
    logic [3:0] r_cnt;

    logic        r_out_valid;
    logic [35:0] r_out;

    t_unit_stat  sq_stat, rot_stat;
    logic [N-1:0] root;
    logic signed [ANG_W-1:0] angle;
    logic signed [S:0] num;
    logic signed [S-1:0] sq_op;
    logic signed [2*S-1:0] prod;

    logic accept, commit;
    logic signed [S-1:0] ax, ay, az;

    assign ax = $signed(i_s_axis_tdata[S-1:0]);
    assign ay = $signed(i_s_axis_tdata[2*S-1:S]);
    assign az = $signed(i_s_axis_tdata[3*S-1:2*S]);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign commit = (r_state == S_DECIDE) && (!r_out_valid || i_m_axis_tready);

    // roll: num=y, a=x; pitch: num=-x, a=y; b is z in both
    assign sq_op = (r_state == S_SQA) ? (r_phase ? r_y : r_x) : r_z;
    assign prod  = sq_op * sq_op;
    assign num   = r_phase ? -{r_x[S-1], r_x} : {r_y[S-1], r_y};

    tgrs_isqrt #(.SAMPLE_BITS(S)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ROOT_GO),
        .i_val   (r_sq),
        .o_stat  (sq_stat),
        .o_root  (root)
    );

    tgrs_cordic #(.SAMPLE_BITS(S)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ROT_GO),
        .i_px    (root),
        .i_num   (num),
        .o_stat  (rot_stat),
        .o_angle (angle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_s_axis_tuser == CMD_ARM || (ax == '0 && ay == '0 && az == '0))
                        n_state = S_DECIDE;
                    else
                        n_state = S_SQA;
                end
            end
            S_SQA:       n_state = S_SQB;
            S_SQB:       n_state = S_ROOT_GO;
            S_ROOT_GO:   n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: if (sq_stat.done) n_state = S_ROT_GO;
            S_ROT_GO:    n_state = S_ROT_WAIT;
            S_ROT_WAIT:  if (rot_stat.done) n_state = r_phase ? S_DECIDE : S_SQA;
            S_DECIDE:    if (commit) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // row-scan decision
    logic signed [12:0] roll_e, thr_e;
    logic [11:0]        pmag;
    logic               in_win, do_start, do_end;
    logic [3:0]         cnt_inc;
    logic               n_active, n_row, n_blue, n_red;
    logic [3:0]         n_cnt;
    logic [2:0]         n_ev;

    always_comb begin
        roll_e   = 13'(r_roll);
        thr_e    = $signed({2'b00, r_thr});
        pmag     = r_pitch[ANG_W-1] ? 12'(-r_pitch) : 12'(r_pitch);
        in_win   = ({1'b0, pmag} <= {2'b00, r_win});
        cnt_inc  = (r_cnt == 4'hF) ? r_cnt : r_cnt + 4'd1;
        do_start = 1'b0;
        do_end   = 1'b0;
        n_active = r_active;
        n_row    = r_row;
        n_blue   = r_blue;
        n_red    = r_red;
        n_cnt    = r_cnt;
        n_ev     = EV_NONE;
        if (r_cmd == CMD_ARM) begin
            n_cnt  = '0;
            n_row  = 1'b0;
            n_blue = 1'b0;
            n_red  = 1'b0;
            if (r_rows_cfg == '0) begin
                n_active = 1'b0;
                n_ev     = EV_EMPTY;
            end else begin
                n_active = 1'b1;
            end
        end else if (r_valid && r_active) begin
            do_start = (roll_e <= -thr_e) && in_win && !r_row;
            do_end   = (roll_e >= thr_e) && in_win && r_row;
            if (do_start) begin
                n_row  = 1'b1;
                n_blue = 1'b1;
                n_ev   = EV_ROW_START;
            end else begin
                if (do_end) begin
                    n_row  = 1'b0;
                    n_blue = 1'b0;
                    n_red  = 1'b0;
                    n_cnt  = cnt_inc;
                    n_ev   = EV_ROW_END;
                    if (cnt_inc >= r_rows_cfg) begin
                        n_active = 1'b0;
                        n_ev     = EV_SCAN_DONE;
                    end
                end
                if (n_row) begin
                    if ({1'b0, pmag} > {2'b00, r_warn}) begin
                        n_blue = 1'b0;
                        n_red  = 1'b1;
                    end else if ({1'b0, pmag} < {2'b00, r_warn}) begin
                        n_blue = 1'b1;
                        n_red  = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg  <= 4'd1;
            r_thr       <= CFG_W'(720);
            r_win       <= CFG_W'(160);
            r_warn      <= CFG_W'(80);
            r_active    <= 1'b0;
            r_row       <= 1'b0;
            r_blue      <= 1'b0;
            r_red       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROWS: r_rows_cfg <= i_cfg_data[3:0];
                    CFG_THR:  r_thr      <= i_cfg_data;
                    CFG_WIN:  r_win      <= i_cfg_data;
                    CFG_WARN: r_warn     <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (accept) begin
                r_cmd   <= i_s_axis_tuser;
                r_x     <= ax;
                r_y     <= ay;
                r_z     <= az;
                r_valid <= (i_s_axis_tuser == CMD_SAMPLE) &&
                           !(ax == '0 && ay == '0 && az == '0);
                r_roll  <= '0;
                r_pitch <= '0;
                r_phase <= 1'b0;
            end
            if (r_state == S_SQA) r_sq <= $unsigned(prod);
            if (r_state == S_SQB) r_sq <= r_sq + $unsigned(prod);
            if (r_state == S_ROT_WAIT && rot_stat.done) begin
                if (r_phase) r_pitch <= angle;
                else         r_roll  <= angle;
                r_phase <= 1'b1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) r_out_valid <= 1'b0;
            if (commit) begin
                r_active    <= n_active;
                r_row       <= n_row;
                r_blue      <= n_blue;
                r_red       <= n_red;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
                r_out       <= {n_active, n_cnt, n_red, n_blue, n_row, r_valid,
                                12'(r_pitch), 12'(r_roll), n_ev};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out};

    a_row_needs_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> !r_row) else $error("row in progress without active scan");
    a_red_needs_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_row |-> (!r_red && !r_blue)) else $error("indicator lit outside a row");
    a_start_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2:0] == EV_ROW_START) |-> o_m_axis_tdata[28])
        else $error("row start beat without scanning");
    a_root_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT_GO) |-> !sq_stat.busy) else $error("root started while busy");
    a_rot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT_GO) |-> !rot_stat.busy) else $error("cordic started while busy");

endmodule

[src/tgrs_isqrt.sv]
// Bit-serial integer square root of (sum of squares << 2*PREC_SHIFT).
// Depends on tgrs_pkg.
module tgrs_isqrt import tgrs_pkg::*; #(
    parameter int SAMPLE_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [2*SAMPLE_BITS-1:0]    i_val,
    output t_unit_stat                  o_stat,
    output logic [SAMPLE_BITS+11:0]     o_root
);
    localparam int N   = SAMPLE_BITS + PREC_SHIFT;
    localparam int RW  = 2 * N;
    localparam int CW  = $clog2(N + 1);

    logic [RW-1:0]  r_rad;
    logic [N+1:0]   r_rem;
    logic [N-1:0]   r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_done;

    logic [N+1:0]   rem_sh;
    logic [N+1:0]   trial;

    assign rem_sh = {r_rem[N-1:0], r_rad[RW-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= {i_val, {(2*PREC_SHIFT){1'b0}}};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(N);
            end else if (r_cnt != '0) begin
                r_rad <= {r_rad[RW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[N-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[N-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) r_done <= 1'b1;
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

[src/tgrs_cordic.sv]
// Vectoring CORDIC, one micro-rotation per cycle, rounded angle out.
// Depends on tgrs_pkg.
module tgrs_cordic import tgrs_pkg::*; #(
    parameter int SAMPLE_BITS = 14
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [SAMPLE_BITS+11:0]         i_px,
    input  logic signed [SAMPLE_BITS:0]     i_num,
    output t_unit_stat                      o_stat,
    output logic signed [ANG_W-1:0]         o_angle
);
    localparam int N = SAMPLE_BITS + PREC_SHIFT;
    localparam int W = SAMPLE_BITS + 15;

    logic signed [W-1:0]     r_px, r_py;
    logic signed [ACC_W-1:0] r_acc;
    logic [ITER_W-1:0]       r_i;
    logic                    r_busy, r_done;

    logic signed [W-1:0]     dx, dy;
    logic signed [ACC_W-1:0] tab;
    logic [ACC_W-1:0]        mag, rnd;

    assign dx  = r_py >>> r_i;
    assign dy  = r_px >>> r_i;
    assign tab = $signed({1'b0, f_atan(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_px   <= $signed({{(W-N){1'b0}}, i_px});
                r_py   <= $signed({{(W-SAMPLE_BITS-1-PREC_SHIFT){i_num[SAMPLE_BITS]}},
                                   i_num, {PREC_SHIFT{1'b0}}});
                r_acc  <= '0;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_py > 0) begin
                    r_px  <= r_px + dx;
                    r_py  <= r_py - dy;
                    r_acc <= r_acc + tab;
                end else begin
                    r_px  <= r_px - dx;
                    r_py  <= r_py + dy;
                    r_acc <= r_acc - tab;
                end
                r_i <= r_i + 1'b1;
                if (r_i == ITER_W'(CORDIC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // round half away from zero
    assign mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign rnd = (mag + ACC_W'(1 << (ROUND_SH - 1))) >> ROUND_SH;
    assign o_angle = r_acc[ACC_W-1] ? ANG_W'(-rnd) : ANG_W'(rnd);

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
